[rtl/pbe_pkg.sv]
// Package for the PWM bit-plane encoder: geometry constants, field widths
// and the structs passed between the lanes, the merge stage and the top level.
// No dependencies.
package pbe_pkg;

  // Display geometry
  localparam int PLANES            = 16;
  localparam int PIXELS_PER_COLUMN = 256;
  localparam int PIXELS_PER_GROUP  = 8;
  localparam int GROUPS_PER_PLANE  = PIXELS_PER_COLUMN / PIXELS_PER_GROUP;
  localparam int BYTES_PER_LINE    = GROUPS_PER_PLANE * PLANES;

  // Field widths
  localparam int LEVEL_W = 4;
  localparam int LINE_W  = 7;
  localparam int GROUP_W = 5;
  localparam int PACK_W  = LEVEL_W * PIXELS_PER_GROUP;
  localparam int ADDR_W  = 16;
  localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;

  localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(PLANES - 1);

  // Plane bits that one pixel lane produces
  typedef struct packed {
    logic red;
    logic green;
    logic blue;
  } lane_bits_t;

  // Step request from the plane sequencer to the merge stage
  typedef struct packed {
    logic               emit;
    logic               last;
    logic [PLANE_W-1:0] plane;
  } step_t;

endpackage

[rtl/pbe_if.sv]
// Channel interfaces of the PWM bit-plane encoder: pixel group requests in,
// plane byte requests out. Depends on pbe_pkg.
interface pbe_in_if;
  logic                            valid;
  logic                            ready;
  logic                            image_select;
  logic [pbe_pkg::LINE_W-1:0]      line_index;
  logic [pbe_pkg::GROUP_W-1:0]     group_index;
  logic [pbe_pkg::PACK_W-1:0]      red_levels;
  logic [pbe_pkg::PACK_W-1:0]      green_levels;
  logic [pbe_pkg::PACK_W-1:0]      blue_levels;

  modport source (output valid, image_select, line_index, group_index,
                  red_levels, green_levels, blue_levels, input ready);
  modport sink   (input valid, image_select, line_index, group_index,
                  red_levels, green_levels, blue_levels, output ready);
endinterface

interface pbe_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  image_out;
  logic [pbe_pkg::ADDR_W-1:0]            byte_address;
  logic [pbe_pkg::PIXELS_PER_GROUP-1:0]  red_byte;
  logic [pbe_pkg::PIXELS_PER_GROUP-1:0]  green_byte;
  logic [pbe_pkg::PIXELS_PER_GROUP-1:0]  blue_byte;
  logic                                  last_plane;

  modport source (output valid, image_out, byte_address, red_byte, green_byte,
                  blue_byte, last_plane, input ready);
  modport sink   (input valid, image_out, byte_address, red_byte, green_byte,
                  blue_byte, last_plane, output ready);
endinterface

[rtl/pwm_bit_plane_encoder_top.sv]
// Top level of the PWM bit-plane encoder: plane sequencer, eight pixel
// lanes and the merge stage. Depends on pbe_pkg, pbe_if, pbe_lane, pbe_merge.
//
//   channel   direction  payload
//   in_ch     sink       image_select, line_index, group_index, r/g/b levels
//   out_ch    source     image_out, byte_address, r/g/b bytes, last_plane
//
// Each pixel group yields PLANES results, one per cycle from the plane
// counter while out_ch does not stall; the next group is taken in the cycle
// its predecessor's last plane is issued, so planes flow without gaps.
// Reset (rst_n low, synchronous) empties the sequencer and the output register.
// A stall on out_ch holds the plane counter; the output register holds the
// pending result meanwhile.
module pwm_bit_plane_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  pbe_in_if.sink     in_ch,
  pbe_out_if.source  out_ch
);
  import pbe_pkg::*;

  logic                busy_r, busy_nxt;
  logic [PLANE_W-1:0]  plane_r, plane_nxt;
  logic                image_r;
  logic [LINE_W-1:0]   line_r;
  logic [GROUP_W-1:0]  group_r;
  logic [PACK_W-1:0]   red_r, green_r, blue_r;

  logic                free;
  logic                accept;
  logic                on_last;
  step_t               step;
  lane_bits_t [PIXELS_PER_GROUP-1:0] lane_bits;

  // Issue one plane per cycle while the output register can take it
  assign on_last     = (plane_r == LAST_PLANE);
  assign step.emit   = busy_r && free;
  assign step.last   = on_last;
  assign step.plane  = plane_r;
  assign in_ch.ready = !busy_r || (free && on_last);
  assign accept      = in_ch.valid && in_ch.ready;

  // Advance the plane counter; restart on a new request
  always_comb begin
    busy_nxt  = busy_r;
    plane_nxt = plane_r;
    if (accept) begin
      busy_nxt  = 1'b1;
      plane_nxt = '0;
    end else if (step.emit) begin
      if (on_last) begin
        busy_nxt = 1'b0;
      end else begin
        plane_nxt = plane_r + PLANE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      plane_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      plane_r <= plane_nxt;
    end
  end

  // Hold the accepted pixel group
  always_ff @(posedge clk) begin
    if (accept) begin
      image_r <= in_ch.image_select;
      line_r  <= in_ch.line_index;
      group_r <= in_ch.group_index;
      red_r   <= in_ch.red_levels;
      green_r <= in_ch.green_levels;
      blue_r  <= in_ch.blue_levels;
    end
  end

  // One lane per pixel; pixel 0 sits in the top nibble
  for (genvar i = 0; i < PIXELS_PER_GROUP; i++) begin : g_lane
    pbe_lane u_lane (
      .red_level   (red_r[PACK_W-1-LEVEL_W*i -: LEVEL_W]),
      .green_level (green_r[PACK_W-1-LEVEL_W*i -: LEVEL_W]),
      .blue_level  (blue_r[PACK_W-1-LEVEL_W*i -: LEVEL_W]),
      .plane       (plane_r),
      .bits        (lane_bits[i])
    );
  end

  pbe_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .lane_bits    (lane_bits),
    .image_select (image_r),
    .line_index   (line_r),
    .group_index  (group_r),
    .free         (free),
    .out_ch       (out_ch)
  );

endmodule

[rtl/pbe_lane.sv]
// One pixel lane: thermometer compare of the red, green and blue levels
// against the current plane index. Depends on pbe_pkg.
module pbe_lane (
  input  logic [pbe_pkg::LEVEL_W-1:0] red_level,
  input  logic [pbe_pkg::LEVEL_W-1:0] green_level,
  input  logic [pbe_pkg::LEVEL_W-1:0] blue_level,
  input  logic [pbe_pkg::PLANE_W-1:0] plane,
  output pbe_pkg::lane_bits_t         bits
);
  import pbe_pkg::*;

  logic [LEVEL_W-1:0] threshold;

  // Cast the plane index to the level width
  assign threshold = LEVEL_W'(plane);

  // Set a bit where the level exceeds the plane
  always_comb begin
    bits.red   = (red_level   > threshold);
    bits.green = (green_level > threshold);
    bits.blue  = (blue_level  > threshold);
  end

endmodule

[rtl/pbe_merge.sv]
// Merge stage: packs the lane bits into plane bytes, forms the display
// memory address and holds the result in the output register.
// Depends on pbe_pkg and pbe_if.
module pbe_merge (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  pbe_pkg::step_t                          step,
  input  pbe_pkg::lane_bits_t [pbe_pkg::PIXELS_PER_GROUP-1:0] lane_bits,
  input  logic                                    image_select,
  input  logic [pbe_pkg::LINE_W-1:0]              line_index,
  input  logic [pbe_pkg::GROUP_W-1:0]             group_index,
  output logic                                    free,
  pbe_out_if.source                               out_ch
);
  import pbe_pkg::*;

  logic                        out_valid_r, out_valid_nxt;
  logic                        image_r;
  logic [ADDR_W-1:0]           addr_r, addr_nxt;
  logic [PIXELS_PER_GROUP-1:0] red_r, green_r, blue_r;
  logic [PIXELS_PER_GROUP-1:0] red_nxt, green_nxt, blue_nxt;
  logic                        last_r;

  // Output register may take a new request when empty or being drained
  assign free = !out_valid_r || out_ch.ready;

  // Pack lanes: pixel 0 lands in bit 7
  always_comb begin
    for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
      red_nxt[PIXELS_PER_GROUP-1-i]   = lane_bits[i].red;
      green_nxt[PIXELS_PER_GROUP-1-i] = lane_bits[i].green;
      blue_nxt[PIXELS_PER_GROUP-1-i]  = lane_bits[i].blue;
    end
  end

  // Address: line * bytes per line + plane * groups per plane + group, wrapped
  assign addr_nxt = ADDR_W'(line_index) * ADDR_W'(BYTES_PER_LINE)
                  + ADDR_W'(step.plane) * ADDR_W'(GROUPS_PER_PLANE)
                  + ADDR_W'(group_index);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold valid across stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load payload on each emitted plane
  always_ff @(posedge clk) begin
    if (step.emit) begin
      image_r <= image_select;
      addr_r  <= addr_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      last_r  <= step.last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.image_out    = image_r;
  assign out_ch.byte_address = addr_r;
  assign out_ch.red_byte     = red_r;
  assign out_ch.green_byte   = green_r;
  assign out_ch.blue_byte    = blue_r;
  assign out_ch.last_plane   = last_r;

endmodule

[tb/pwm_bit_plane_encoder_top_tb.sv]
// Testbench for pwm_bit_plane_encoder_top: drives pixel group requests, predicts the sixteen
// thermometer-coded plane requests of each one and checks them in order.
// Depends on pbe_pkg, pbe_if and the encoder RTL.
module pwm_bit_plane_encoder_top_tb;
  import pbe_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 12;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic               image;
    logic [LINE_W-1:0]  line;
    logic [GROUP_W-1:0] group;
    logic [PACK_W-1:0]  red;
    logic [PACK_W-1:0]  green;
    logic [PACK_W-1:0]  blue;
  } pixel_group_t;

  typedef struct packed {
    logic              image;
    logic [ADDR_W-1:0] address;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              last;
  } plane_bytes_t;

  logic clk;
  logic rst_n;

  pbe_in_if  in_ch();
  pbe_out_if out_ch();

  pwm_bit_plane_encoder_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  plane_bytes_t expected_planes[$];
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int error_count    = 0;
  int groups_sent    = 0;
  int planes_checked = 0;
  int quiet_cycles   = 0;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Plane byte of one channel: bit 7-i set when pixel i exceeds the plane
  function automatic logic [7:0] thermometer_byte(logic [PACK_W-1:0] levels, int plane);
    logic [7:0] plane_bits;
    plane_bits = '0;
    for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
      if (int'(levels[PACK_W-LEVEL_W-LEVEL_W*i +: LEVEL_W]) > plane) plane_bits[7-i] = 1'b1;
    end
    return plane_bits;
  endfunction

  // Level word biased towards the thermometer extremes
  function automatic logic [PACK_W-1:0] random_levels();
    logic [PACK_W-1:0] levels;
    if ($urandom_range(0, 3) == 0) return PACK_W'($urandom);
    for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
      case ($urandom_range(0, 3))
        0: levels[LEVEL_W*i +: LEVEL_W] = '0;
        1: levels[LEVEL_W*i +: LEVEL_W] = '1;
        default: levels[LEVEL_W*i +: LEVEL_W] = LEVEL_W'($urandom);
      endcase
    end
    return levels;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Offer one pixel group, with random idle cycles ahead of it; hold until taken
  task automatic send_group(pixel_group_t g);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.image_select <= g.image;
    in_ch.line_index   <= g.line;
    in_ch.group_index  <= g.group;
    in_ch.red_levels   <= g.red;
    in_ch.green_levels <= g.green;
    in_ch.blue_levels  <= g.blue;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    groups_sent++;
  endtask

  // Hold off the sender until every predicted plane has arrived
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_planes.size() != 0) @(posedge clk);
  endtask

  // Predict on each accepted group, then check each accepted plane request
  always @(posedge clk) begin
    plane_bytes_t want;
    plane_bytes_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        for (int p = 0; p < PLANES; p++) begin
          want.image   = in_ch.image_select;
          want.address = ADDR_W'(int'(in_ch.line_index) * BYTES_PER_LINE
                                 + p * GROUPS_PER_PLANE + int'(in_ch.group_index));
          want.red     = thermometer_byte(in_ch.red_levels, p);
          want.green   = thermometer_byte(in_ch.green_levels, p);
          want.blue    = thermometer_byte(in_ch.blue_levels, p);
          want.last    = (p == PLANES - 1);
          expected_planes.push_back(want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.image_out, out_ch.byte_address, out_ch.red_byte, out_ch.green_byte,
                out_ch.blue_byte, out_ch.last_plane};
        if (expected_planes.size() == 0) begin
          report_mismatch("plane request with nothing expected, byte_address",
                          got.address, 0);
        end else begin
          want = expected_planes.pop_front();
          planes_checked++;
          if (got.image !== want.image)     report_mismatch("image_out", got.image, want.image);
          if (got.address !== want.address)
            report_mismatch("byte_address", got.address, want.address);
          if (got.red !== want.red)         report_mismatch("red_byte", got.red, want.red);
          if (got.green !== want.green)     report_mismatch("green_byte", got.green, want.green);
          if (got.blue !== want.blue)       report_mismatch("blue_byte", got.blue, want.blue);
          if (got.last !== want.last)       report_mismatch("last_plane", got.last, want.last);
        end
      end
    end
  end

  // Receiver: stall at random at the current idle rate
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when nothing is accepted for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Level extremes, ramps and per-channel patterns
  task automatic test_level_patterns();
    send_group('{1'b0, 7'd5, 5'd3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
    send_group('{1'b1, 7'd5, 5'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_group('{1'b0, 7'd9, 5'd0, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98});
    send_group('{1'b1, 7'd9, 5'd1, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'h8877_6655});
    send_group('{1'b0, 7'd9, 5'd2, 32'hF000_0000, 32'h0000_000F, 32'h1111_1111});
    send_group('{1'b1, 7'd9, 5'd3, 32'hEEEE_EEEE, 32'h7777_7777, 32'h8888_8888});
    send_group('{1'b0, 7'd9, 5'd4, 32'h1000_0001, 32'hE00F_F00E, 32'h0F00_00F0});
    wait_drained();
  endtask

  // Address corners: first and last line and group, both images
  task automatic test_address_corners();
    send_group('{1'b0, 7'd0,   5'd0,  32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9});
    send_group('{1'b1, 7'd127, 5'd31, 32'hFFFF_0000, 32'h0000_FFFF, 32'h5A5A_A5A5});
    send_group('{1'b0, 7'd127, 5'd0,  32'hC3C3_3C3C, 32'h2468_ACE0, 32'h1357_9BDF});
    send_group('{1'b1, 7'd0,   5'd31, 32'h7F7F_F7F7, 32'h0101_1010, 32'hFEFE_EFEF});
    send_group('{1'b1, 7'd64,  5'd16, 32'h8000_0008, 32'h4444_BBBB, 32'h3C3C_C3C3});
    send_group('{1'b0, 7'd63,  5'd15, 32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0BAD_1DEA});
    wait_drained();
  endtask

  // Random groups: mostly column sweeps of consecutive groups, some scattered
  task automatic test_random_groups(int count, int send_pct, int recv_pct);
    pixel_group_t g;
    int sent;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < count) begin
      g.image = 1'($urandom);
      g.line  = LINE_W'($urandom);
      g.group = GROUP_W'($urandom);
      for (int n = $urandom_range(1, 8); n > 0 && sent < count; n--) begin
        g.red   = random_levels();
        g.green = random_levels();
        g.blue  = random_levels();
        send_group(g);
        sent++;
        if ($urandom_range(0, 3) == 0) begin
          g.line  = LINE_W'($urandom);
          g.group = GROUP_W'($urandom);
        end else begin
          g.group = g.group + 1'b1;
        end
      end
    end
    wait_drained();
  endtask

  // Main sequence
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.image_select = 1'b0;
    in_ch.line_index   = '0;
    in_ch.group_index  = '0;
    in_ch.red_levels   = '0;
    in_ch.green_levels = '0;
    in_ch.blue_levels  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 16;
    recv_idle_pct = 82;
    test_level_patterns();
    test_address_corners();
    test_random_groups(130, 16, 82);
    test_random_groups(130, 82, 16);
    test_random_groups(140, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d pixel groups and %0d plane requests under three idle patterns,",
             groups_sent, planes_checked);
    $display("including all-dark, all-full and address corner groups; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
